// File: src/stereo_led_bar_meter_decay_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo LED bar meter
// Implication checks on a clock, with an active-low asynchronous reset that
// disables them. The bodies are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STEREO_LED_BAR_METER_DECAY_TOP_ASSERT_SVH
`define STEREO_LED_BAR_METER_DECAY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: ante |-> cons
`define SLBM_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("slbm assertion failed");

// Next-cycle implication: ante |=> cons
`define SLBM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("slbm assertion failed");

`else

`define SLBM_ASSERT(lbl, clk, rstn, ante, cons)
`define SLBM_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: src/slbm_pkg.sv
// ----------------------------------------------------------------------------
// slbm_pkg
// Types, constants and the dB segment table of the stereo LED bar meter.
// ----------------------------------------------------------------------------
package slbm_pkg;

  // Field widths
  localparam int LEVEL_W       = 15;
  localparam int COUNT_W       = 4;
  localparam int DECAY_W       = 3;
  localparam int SUM_W         = 7;   // fresh + prev * weight, at most 88
  localparam int REM_W         = 3;   // divisor is at most 8
  localparam int PEAK_BITS_DEF = 15;

  // Mapping constants
  localparam int DB_STEPS  = 44;
  localparam int LIN_STEPS = 11;
  localparam int MAX_COUNT = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DECAY_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_DB_SCALE = 1'b0,
    CFG_DECAY_WEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
  } level_t;

  typedef struct packed {
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;
  } count_t;

  // Segments lit against the dB-scaled index
  localparam logic [COUNT_W-1:0] SEG_TABLE [DB_STEPS] = '{
    4'd0,  4'd2,  4'd3,  4'd5,  4'd5,  4'd6,  4'd6,  4'd6,  4'd7,  4'd7,  4'd7,
    4'd7,  4'd8,  4'd8,  4'd8,  4'd8,  4'd8,  4'd9,  4'd9,  4'd9,  4'd9,  4'd9,
    4'd9,  4'd9,  4'd9,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11
  };

endpackage

// File: src/stereo_led_bar_meter_decay_top.sv
// ----------------------------------------------------------------------------
// stereo_led_bar_meter_decay_top
// Stereo bargraph meter: maps two peak levels to lit-segment counts (dB table
// or linear) and smooths each against its last count with a shared divider.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_data_i  (level_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (count_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  An item passes a mapping step, a sum step, eight steps of the shared
//  restoring divider (four quotient bits per channel, left then right) and
//  an output load before the next item is accepted.
//  The result register frees the input side; a stalled output holds the
//  sequencer only when a second result is ready to load.
//  Reset sets dB mode, no decay and both last counts to zero.
//  The configuration port is always ready.

`include "stereo_led_bar_meter_decay_top_assert.svh"

module stereo_led_bar_meter_decay_top
  import slbm_pkg::*;
#(
  parameter int PEAK_BITS = PEAK_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  level_t                in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output count_t                out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Derived sizes
  localparam int StepW   = $clog2(DB_STEPS);
  localparam int ProdW   = LEVEL_W + StepW;
  localparam int FullInt = (PEAK_BITS >= LEVEL_W) ? (1 << LEVEL_W) - 1
                                                  : (1 << PEAK_BITS) - 1;
  localparam logic [LEVEL_W-1:0] FullScale = LEVEL_W'(FullInt);
  localparam logic [ProdW-1:0]   DbIdxMax  = ProdW'(DB_STEPS - 1);
  localparam logic [ProdW-1:0]   DbMul     = ProdW'(DB_STEPS);
  localparam logic [ProdW-1:0]   LinMul    = ProdW'(LIN_STEPS);
  localparam int DivSteps = COUNT_W;
  localparam int StepCntW = $clog2(2 * DivSteps);
  localparam int BitW     = $clog2(DivSteps);
  localparam logic [StepCntW-1:0] StepLast = StepCntW'(2 * DivSteps - 1);
  localparam logic [BitW-1:0]     BitTop   = BitW'(DivSteps - 1);
  localparam logic [COUNT_W-1:0]  MaxCnt   = COUNT_W'(MAX_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_SUM,
    S_DIV,
    S_DONE
  } state_e;

  // Level to segment count, one multiplier shared by both scales
  function automatic logic [COUNT_W-1:0] map_level(logic [LEVEL_W-1:0] raw,
                                                   logic db);
    logic [LEVEL_W-1:0] lvl;
    logic [ProdW-1:0]   prod;
    logic [ProdW-1:0]   scaled;
    lvl    = (raw > FullScale) ? FullScale : raw;
    prod   = ProdW'(lvl) * (db ? DbMul : LinMul);
    scaled = prod >> PEAK_BITS;
    if (db) begin
      if (scaled > DbIdxMax) begin
        scaled = DbIdxMax;
      end
      return SEG_TABLE[scaled[StepW-1:0]];
    end
    return scaled[COUNT_W-1:0];
  endfunction

  state_e                state_q;
  logic [StepCntW-1:0]   step_q;
  logic                  use_db_q;
  logic [DECAY_W-1:0]    decay_q;
  logic [COUNT_W-1:0]    prev_q  [2];
  logic [COUNT_W-1:0]    fresh_q [2];
  logic [SUM_W-1:0]      sum_q   [2];
  logic [REM_W-1:0]      rem_q;
  logic [COUNT_W-1:0]    quot_q;
  level_t                lvl_q;
  logic                  out_valid_q;
  count_t                out_data_q;

  // Divider step signals
  logic                  div_ch;
  logic [BitW-1:0]       div_bit;
  logic                  div_first;
  logic [SUM_W-1:0]      dividend;
  logic [COUNT_W-1:0]    divisor;
  logic [REM_W-1:0]      rem_in;
  logic [REM_W:0]        trial;
  logic                  trial_ge;
  logic [REM_W-1:0]      rem_d;
  logic [COUNT_W-1:0]    quot_d;
  logic [COUNT_W-1:0]    count_d;
  logic [COUNT_W-1:0]    dividend_lo;

  // Range flags for the checks
  logic                  out_in_range;
  logic                  prev_in_range;

  // Shared restoring divider, one quotient bit a cycle
  always_comb begin
    div_ch      = step_q[StepCntW-1];
    div_bit     = step_q[BitW-1:0];
    div_first   = (div_bit == '0);
    dividend    = sum_q[div_ch];
    dividend_lo = dividend[COUNT_W-1:0];
    divisor     = COUNT_W'(decay_q) + COUNT_W'(1);
    rem_in      = div_first ? dividend[SUM_W-1:COUNT_W] : rem_q;
    trial       = {rem_in, dividend_lo[BitTop - div_bit]};
    trial_ge    = (trial >= divisor);
    rem_d       = trial_ge ? REM_W'(trial - divisor) : trial[REM_W-1:0];
    quot_d      = {(div_first ? {(COUNT_W-1){1'b0}} : quot_q[COUNT_W-2:0]), trial_ge};
    count_d     = (quot_d > MaxCnt) ? MaxCnt : quot_d;
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      use_db_q    <= 1'b1;
      decay_q     <= '0;
      prev_q[0]   <= '0;
      prev_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_USE_DB_SCALE: use_db_q <= cfg_data_i[0];
          CFG_DECAY_WEIGHT: decay_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // result taken; a load in the same cycle sets it again below
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            lvl_q   <= in_data_i;
            state_q <= S_MAP;
          end
        end
        S_MAP: begin
          fresh_q[0] <= map_level(lvl_q.left_level, use_db_q);
          fresh_q[1] <= map_level(lvl_q.right_level, use_db_q);
          state_q    <= S_SUM;
        end
        S_SUM: begin
          sum_q[0] <= SUM_W'(fresh_q[0]) + SUM_W'(prev_q[0]) * SUM_W'(decay_q);
          sum_q[1] <= SUM_W'(fresh_q[1]) + SUM_W'(prev_q[1]) * SUM_W'(decay_q);
          step_q   <= '0;
          state_q  <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= rem_d;
          quot_q <= quot_d;
          if (div_bit == BitTop) begin
            prev_q[div_ch] <= count_d;
          end
          step_q <= step_q + StepCntW'(1);
          if (step_q == StepLast) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_data_q.left_count  <= prev_q[0];
            out_data_q.right_count <= prev_q[1];
            out_valid_q            <= 1'b1;
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  assign out_in_range  = (out_data_o.left_count <= MaxCnt) &&
                         (out_data_o.right_count <= MaxCnt);
  assign prev_in_range = (prev_q[0] <= MaxCnt) && (prev_q[1] <= MaxCnt);

  // Checks
  `SLBM_ASSERT(a_out_range, clk_i, rst_ni, out_valid_o, out_in_range)
  `SLBM_ASSERT(a_prev_range, clk_i, rst_ni, 1'b1, prev_in_range)
  `SLBM_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `SLBM_ASSERT_NXT(a_div_ends, clk_i, rst_ni, (state_q == S_DIV) && (step_q == StepLast), state_q == S_DONE)

endmodule
